// File: sv/gamepad_report_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Gamepad report encoder assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_ENCODER_UNIT_MACROS_SVH
`define GAMEPAD_REPORT_ENCODER_UNIT_MACROS_SVH

// same-cycle implication
`define GRE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/gre_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad report encoder package
// Event codes, register indexes, report layout constants and the hat
// resolution and report packing functions.
// ----------------------------------------------------------------------------
`default_nettype none

package gre_pkg;

   // event codes
   typedef enum logic [1:0] {
      OP_BUTTON    = 2'd0,
      OP_DIRECTION = 2'd1,
      OP_STICK     = 2'd2,
      OP_NEUTRAL   = 2'd3
   } opcode_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_NEUTRAL_HAT   = 2'd0,
      CSR_NEUTRAL_STICK = 2'd1
   } csr_index_type;

   localparam int unsigned ButtonCount = 14;
   localparam int unsigned ReportBytes = 8;
   localparam int unsigned ByteBits    = 7;
   localparam int unsigned WordBits    = ReportBytes * ByteBits;
   localparam int unsigned CountBits   = $clog2(ReportBytes);

   typedef logic [ButtonCount-1:0] buttons_type;
   typedef logic [3:0]             hat_type;
   typedef logic [7:0]             axis_type;
   typedef logic [WordBits-1:0]    word_type;
   typedef logic [CountBits-1:0]   count_type;

   localparam hat_type  NeutralHatReset   = 4'd8;
   localparam axis_type NeutralStickReset = 8'd128;
   localparam count_type LastByteIdx      = CountBits'(ReportBytes - 1);

   // hat codes
   localparam hat_type HatUp        = 4'd0;
   localparam hat_type HatUpRight   = 4'd1;
   localparam hat_type HatRight     = 4'd2;
   localparam hat_type HatDownRight = 4'd3;
   localparam hat_type HatDown      = 4'd4;
   localparam hat_type HatDownLeft  = 4'd5;
   localparam hat_type HatLeft      = 4'd6;
   localparam hat_type HatUpLeft    = 4'd7;
   localparam hat_type HatCenter    = 4'd8;

   // direction mask bit positions
   localparam int unsigned DirUp    = 0;
   localparam int unsigned DirDown  = 1;
   localparam int unsigned DirLeft  = 2;
   localparam int unsigned DirRight = 3;

   // resolve a held-direction mask to a hat code; opposites cancel
   function automatic hat_type resolve_hat(input logic [3:0] dirs);
      logic up;
      logic down;
      logic left;
      logic right;
      hat_type hat;
      up    = dirs[DirUp] & ~dirs[DirDown];
      down  = dirs[DirDown] & ~dirs[DirUp];
      left  = dirs[DirLeft] & ~dirs[DirRight];
      right = dirs[DirRight] & ~dirs[DirLeft];
      if (up) begin
         hat = left ? HatUpLeft : (right ? HatUpRight : HatUp);
      end else if (down) begin
         hat = left ? HatDownLeft : (right ? HatDownRight : HatDown);
      end else begin
         hat = left ? HatLeft : (right ? HatRight : HatCenter);
      end
      return hat;
   endfunction

   // pack buttons high, buttons low, hat, LX, LY, RX, RY into one report word
   function automatic word_type pack_report(input buttons_type buttons,
                                            input hat_type     hat,
                                            input axis_type    lx,
                                            input axis_type    ly,
                                            input axis_type    rx,
                                            input axis_type    ry);
      return {(16 - ButtonCount)'(0), buttons, 4'd0, hat, lx, ly, rx, ry};
   endfunction

endpackage

`default_nettype wire

// File: sv/gamepad_report_encoder_unit.sv
// ----------------------------------------------------------------------------
// Gamepad report encoder unit
// Keeps the gamepad report state and sends the packed report as eight
// 7-bit bytes after every event.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event word (button, direction, stick or neutral),
//   taken when req_valid is high and req_stall low. The report state is
//   updated at that edge and the packed 56-bit report is queued.
//   rsp_* carries the report as eight byte words, most significant bits
//   first; rsp_last_byte and bit 7 of rsp_report_byte mark the eighth.
//   If the serializer is free, the first byte appears on the next cycle.
//   Reports leave through the byte serializer, which sends one byte per
//   cycle unless the receiver stalls. A one-entry report buffer takes the
//   next event while the serializer is still draining; req_stall rises
//   only while that buffer is full.
//   When the receiver stalls, the current byte holds and the serializer
//   waits. csr_* writes neutral_hat (index 0) and neutral_stick (index 1);
//   csr_ready is always high and other indexes are dropped.
//   Reset (synchronous) loads the neutral values and empties the buffers.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_report_encoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // event channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [3:0]  req_button_index,
   input  wire logic [3:0]  req_direction_bits,
   input  wire logic        req_key_down,
   input  wire logic        req_stick_side,
   input  wire logic [7:0]  req_stick_x,
   input  wire logic [7:0]  req_stick_y,
   // report byte channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_report_byte,
   output logic             rsp_last_byte,
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

`include "gamepad_report_encoder_unit_macros.svh"

   // configuration registers
   gre_pkg::hat_type      neutral_hat_ff;
   gre_pkg::axis_type     neutral_stick_ff;

   // report state
   gre_pkg::buttons_type  button_bits_ff,     button_bits_in;
   logic [3:0]            held_dirs_ff,       held_dirs_in;
   gre_pkg::hat_type      hat_code_ff,        hat_code_in;
   gre_pkg::axis_type     left_x_ff,          left_x_in;
   gre_pkg::axis_type     left_y_ff,          left_y_in;
   gre_pkg::axis_type     right_x_ff,         right_x_in;
   gre_pkg::axis_type     right_y_ff,         right_y_in;

   // report buffer and serializer
   gre_pkg::word_type     new_word;
   gre_pkg::word_type     pend_word_ff,       pend_word_in;
   logic                  pend_valid_ff,      pend_valid_in;
   gre_pkg::word_type     ser_word_ff,        ser_word_in;
   logic                  ser_valid_ff,       ser_valid_in;
   gre_pkg::count_type    cnt_ff,             cnt_in;

   logic                  accept;
   logic                  byte_taken;
   logic                  ser_done;
   logic                  ser_free;
   logic                  is_last;
   gre_pkg::buttons_type  button_mask;

   assign accept     = req_valid & ~req_stall;
   assign byte_taken = ser_valid_ff & ~rsp_stall;
   assign is_last    = (cnt_ff == gre_pkg::LastByteIdx);
   assign ser_done   = byte_taken & is_last;
   assign ser_free   = ~ser_valid_ff | ser_done;

   assign req_stall       = pend_valid_ff;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = ser_valid_ff;
   assign rsp_last_byte   = is_last;
   assign rsp_report_byte = {is_last,
                             ser_word_ff[gre_pkg::WordBits-1 -: gre_pkg::ByteBits]};

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         neutral_hat_ff   <= gre_pkg::NeutralHatReset;
         neutral_stick_ff <= gre_pkg::NeutralStickReset;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == gre_pkg::CSR_NEUTRAL_HAT) begin
            neutral_hat_ff <= csr_data[3:0];
         end else if (csr_index == gre_pkg::CSR_NEUTRAL_STICK) begin
            neutral_stick_ff <= csr_data;
         end
      end
   end

   // apply the event to the report state
   always_comb begin
      button_bits_in = button_bits_ff;
      held_dirs_in   = held_dirs_ff;
      hat_code_in    = hat_code_ff;
      left_x_in      = left_x_ff;
      left_y_in      = left_y_ff;
      right_x_in     = right_x_ff;
      right_y_in     = right_y_ff;
      button_mask    = gre_pkg::buttons_type'(1) << req_button_index;
      unique case (gre_pkg::opcode_type'(req_opcode))
         gre_pkg::OP_BUTTON: begin
            // indexes past the last button change nothing
            if (req_button_index < 4'(gre_pkg::ButtonCount)) begin
               button_bits_in = req_key_down ? (button_bits_ff | button_mask)
                                             : (button_bits_ff & ~button_mask);
            end
         end
         gre_pkg::OP_DIRECTION: begin
            held_dirs_in = req_key_down ? (held_dirs_ff | req_direction_bits)
                                        : (held_dirs_ff & ~req_direction_bits);
            hat_code_in  = gre_pkg::resolve_hat(held_dirs_in);
         end
         gre_pkg::OP_STICK: begin
            if (req_stick_side) begin
               right_x_in = req_stick_x;
               right_y_in = req_stick_y;
            end else begin
               left_x_in = req_stick_x;
               left_y_in = req_stick_y;
            end
         end
         gre_pkg::OP_NEUTRAL: begin
            button_bits_in = '0;
            held_dirs_in   = '0;
            hat_code_in    = neutral_hat_ff;
            left_x_in      = neutral_stick_ff;
            left_y_in      = neutral_stick_ff;
            right_x_in     = neutral_stick_ff;
            right_y_in     = neutral_stick_ff;
         end
         default: begin
         end
      endcase
      new_word = gre_pkg::pack_report(button_bits_in, hat_code_in, left_x_in,
                                      left_y_in, right_x_in, right_y_in);
   end

   // hold report state, advance on accepted events
   always_ff @(posedge clock) begin
      if (reset) begin
         button_bits_ff <= '0;
         held_dirs_ff   <= '0;
         hat_code_ff    <= gre_pkg::NeutralHatReset;
         left_x_ff      <= gre_pkg::NeutralStickReset;
         left_y_ff      <= gre_pkg::NeutralStickReset;
         right_x_ff     <= gre_pkg::NeutralStickReset;
         right_y_ff     <= gre_pkg::NeutralStickReset;
      end else if (accept) begin
         button_bits_ff <= button_bits_in;
         held_dirs_ff   <= held_dirs_in;
         hat_code_ff    <= hat_code_in;
         left_x_ff      <= left_x_in;
         left_y_ff      <= left_y_in;
         right_x_ff     <= right_x_in;
         right_y_ff     <= right_y_in;
      end
   end

   // route new reports to the serializer or the buffer, shift out bytes
   always_comb begin
      pend_word_in  = pend_word_ff;
      pend_valid_in = pend_valid_ff;
      ser_word_in   = ser_word_ff;
      ser_valid_in  = ser_valid_ff;
      cnt_in        = cnt_ff;
      priority if (ser_free && pend_valid_ff) begin
         ser_word_in   = pend_word_ff;
         ser_valid_in  = 1'b1;
         cnt_in        = '0;
         pend_valid_in = 1'b0;
      end else if (ser_free && accept) begin
         ser_word_in  = new_word;
         ser_valid_in = 1'b1;
         cnt_in       = '0;
      end else if (ser_free) begin
         ser_valid_in = 1'b0;
      end else begin
         if (byte_taken) begin
            ser_word_in = ser_word_ff << gre_pkg::ByteBits;
            cnt_in      = cnt_ff + 1'b1;
         end
         if (accept) begin
            pend_word_in  = new_word;
            pend_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         ser_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         ser_valid_ff  <= ser_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_word_ff <= pend_word_in;
      ser_word_ff  <= ser_word_in;
   end

   // checks
   `GRE_ASSERT_NOW(a_pend_needs_ser, clock, reset, pend_valid_ff, ser_valid_ff,
      "report buffered while serializer idle")
   `GRE_ASSERT_NEXT(a_stall_holds_cnt, clock, reset, ser_valid_ff && rsp_stall,
      ser_valid_ff && $stable(cnt_ff), "byte count moved while receiver stalled")
   `GRE_ASSERT_NEXT(a_busy_buffers, clock, reset, accept && !ser_free,
      pend_valid_ff, "event taken while busy was not buffered")
   `GRE_ASSERT_NEXT(a_drain_idle, clock, reset, ser_done && !pend_valid_ff && !accept,
      !ser_valid_ff, "serializer stayed busy after last byte")

endmodule

`default_nettype wire

// File: verif/gamepad_report_encoder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gamepad report encoder unit test
// Drives button, direction, stick and neutral events into the encoder, keeps
// its own copy of the report state and checks every one of the eight report
// bytes that each event produces. Events idle and replies stall at random, and
// the neutral values are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------

module gamepad_report_encoder_unit_test;

   // indexes past the last register; writes to them must be dropped
   localparam logic [1:0] CsrSpareLo = 2'd2;
   localparam logic [1:0] CsrSpareHi = 2'd3;

   typedef struct {
      gre_pkg::opcode_type opcode;
      logic [3:0]          button_index;
      logic [3:0]          direction_bits;
      logic                key_down;
      logic                stick_side;
      logic [7:0]          stick_x;
      logic [7:0]          stick_y;
   } pad_event_type;

   typedef struct {
      logic [7:0] value;
      logic       is_last;
   } report_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = 2'd0;
   logic [3:0]  req_button_index = 4'd0;
   logic [3:0]  req_direction_bits = 4'd0;
   logic        req_key_down = 1'b0;
   logic        req_stick_side = 1'b0;
   logic [7:0]  req_stick_x = 8'd0;
   logic [7:0]  req_stick_y = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_report_byte;
   logic        rsp_last_byte;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [7:0]  csr_data = 8'd0;

   gamepad_report_encoder_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_button_index   (req_button_index),
      .req_direction_bits (req_direction_bits),
      .req_key_down       (req_key_down),
      .req_stick_side     (req_stick_side),
      .req_stick_x        (req_stick_x),
      .req_stick_y        (req_stick_y),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_report_byte    (rsp_report_byte),
      .rsp_last_byte      (rsp_last_byte),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow report state and neutral settings
   gre_pkg::buttons_type pad_buttons;
   logic [3:0]           pad_dirs;
   gre_pkg::hat_type     pad_hat;
   gre_pkg::axis_type    pad_lx;
   gre_pkg::axis_type    pad_ly;
   gre_pkg::axis_type    pad_rx;
   gre_pkg::axis_type    pad_ry;
   gre_pkg::hat_type     cfg_hat;
   gre_pkg::axis_type    cfg_stick;

   pad_event_type   pending_events[$];
   report_byte_type report_bytes_due[$];

   int  error_count = 0;
   bit  req_taken = 0;
   int  req_gap = 0;
   int  req_calm_left = 0;
   int  rsp_hold_left = 0;
   int  rsp_calm_left = 0;

   // map the held mask to a hat code; opposite directions cancel
   function automatic gre_pkg::hat_type hat_for(input logic [3:0] d);
      logic [1:0]       vert;
      logic [1:0]       horz;
      gre_pkg::hat_type code;
      // vert: 01 up, 10 down; horz: 01 left, 10 right
      vert = {d[gre_pkg::DirDown] & ~d[gre_pkg::DirUp],
              d[gre_pkg::DirUp] & ~d[gre_pkg::DirDown]};
      horz = {d[gre_pkg::DirRight] & ~d[gre_pkg::DirLeft],
              d[gre_pkg::DirLeft] & ~d[gre_pkg::DirRight]};
      case ({vert, horz})
         4'b0100: code = gre_pkg::HatUp;
         4'b0110: code = gre_pkg::HatUpRight;
         4'b0010: code = gre_pkg::HatRight;
         4'b1010: code = gre_pkg::HatDownRight;
         4'b1000: code = gre_pkg::HatDown;
         4'b1001: code = gre_pkg::HatDownLeft;
         4'b0001: code = gre_pkg::HatLeft;
         4'b0101: code = gre_pkg::HatUpLeft;
         default: code = gre_pkg::HatCenter;
      endcase
      return code;
   endfunction

   function automatic void load_neutral();
      pad_buttons = '0;
      pad_dirs    = '0;
      pad_hat     = cfg_hat;
      pad_lx      = cfg_stick;
      pad_ly      = cfg_stick;
      pad_rx      = cfg_stick;
      pad_ry      = cfg_stick;
   endfunction

   // apply one event to the shadow state and queue its eight report bytes
   function automatic void encode_report(input pad_event_type ev);
      logic [55:0]     packed_word;
      report_byte_type entry;
      case (ev.opcode)
         gre_pkg::OP_BUTTON: begin
            if (ev.button_index < gre_pkg::ButtonCount) begin
               pad_buttons[ev.button_index] = ev.key_down;
            end
         end
         gre_pkg::OP_DIRECTION: begin
            if (ev.key_down) begin
               pad_dirs = pad_dirs | ev.direction_bits;
            end else begin
               pad_dirs = pad_dirs & ~ev.direction_bits;
            end
            pad_hat = hat_for(pad_dirs);
         end
         gre_pkg::OP_STICK: begin
            if (ev.stick_side) begin
               pad_rx = ev.stick_x;
               pad_ry = ev.stick_y;
            end else begin
               pad_lx = ev.stick_x;
               pad_ly = ev.stick_y;
            end
         end
         default: load_neutral();
      endcase
      packed_word = {2'b00, pad_buttons, 4'b0000, pad_hat, pad_lx, pad_ly, pad_rx, pad_ry};
      for (int k = 0; k < gre_pkg::ReportBytes; k++) begin
         entry.is_last = (k == gre_pkg::ReportBytes - 1);
         entry.value   = {entry.is_last, packed_word[55 - 7 * k -: 7]};
         report_bytes_due.insert(report_bytes_due.size(), entry);
      end
   endfunction

   function automatic pad_event_type make_event(input gre_pkg::opcode_type op,
                                                input logic [3:0] bidx,
                                                input logic [3:0] dirs,
                                                input logic down,
                                                input logic side,
                                                input logic [7:0] x,
                                                input logic [7:0] y);
      pad_event_type ev;
      ev.opcode         = op;
      ev.button_index   = bidx;
      ev.direction_bits = dirs;
      ev.key_down       = down;
      ev.stick_side     = side;
      ev.stick_x        = x;
      ev.stick_y        = y;
      return ev;
   endfunction

   // append one event to the driver's queue
   function automatic void queue_event(input pad_event_type ev);
      pending_events.insert(pending_events.size(), ev);
   endfunction

   function automatic pad_event_type random_event();
      pad_event_type ev;
      int pick;
      pick = $urandom_range(0, 99);
      ev.opcode = (pick < 35) ? gre_pkg::OP_BUTTON : (pick < 65) ? gre_pkg::OP_DIRECTION :
                  (pick < 85) ? gre_pkg::OP_STICK : gre_pkg::OP_NEUTRAL;
      // mostly real buttons, now and then one of the two unused indexes
      if ($urandom_range(0, 9) == 0) begin
         ev.button_index = 4'($urandom_range(14, 15));
      end else begin
         ev.button_index = 4'($urandom_range(0, 13));
      end
      ev.direction_bits = 4'($urandom);
      ev.key_down       = 1'($urandom);
      ev.stick_side     = 1'($urandom);
      ev.stick_x        = 8'($urandom);
      ev.stick_y        = 8'($urandom);
      return ev;
   endfunction

   // idle length: mostly none or short, a few long, none inside a calm stretch
   function automatic int idle_cycles(input bit calm);
      int pick;
      if (calm) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 30);
   endfunction

   // event driver: hold a word until taken, then idle or present the next one
   always @(negedge clock) begin
      pad_event_type ev;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_calm_left > 0) begin
            req_calm_left--;
         end else if ($urandom_range(0, 199) == 0) begin
            req_calm_left = $urandom_range(40, 120);
         end
         if (!(req_valid && !req_taken)) begin
            if (req_taken) begin
               req_taken = 0;
               req_gap   = idle_cycles(req_calm_left > 0);
            end
            if (req_gap == 0 && pending_events.size() > 0) begin
               ev = pending_events.pop_front();
               req_opcode         <= ev.opcode;
               req_button_index   <= ev.button_index;
               req_direction_bits <= ev.direction_bits;
               req_key_down       <= ev.key_down;
               req_stick_side     <= ev.stick_side;
               req_stick_x        <= ev.stick_x;
               req_stick_y        <= ev.stick_y;
               req_valid          <= 1'b1;
            end else begin
               if (req_gap > 0) begin
                  req_gap--;
               end
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_calm_left > 0) begin
            rsp_calm_left--;
         end else if ($urandom_range(0, 199) == 0) begin
            rsp_calm_left = $urandom_range(40, 120);
         end
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else begin
            rsp_stall <= 1'b0;
            rsp_hold_left = idle_cycles(rsp_calm_left > 0);
         end
      end
   end

   // monitor: predict on each taken event, check each taken report byte
   always @(posedge clock) begin
      report_byte_type want;
      if (!reset) begin
         if (req_valid && req_stall === 1'b0) begin
            encode_report(make_event(gre_pkg::opcode_type'(req_opcode), req_button_index,
                                     req_direction_bits, req_key_down, req_stick_side,
                                     req_stick_x, req_stick_y));
            req_taken = 1;
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (report_bytes_due.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected report byte %02h last %b at %0t",
                           rsp_report_byte, rsp_last_byte, $realtime);
               end
            end else begin
               want = report_bytes_due.pop_front();
               if (rsp_report_byte !== want.value || rsp_last_byte !== want.is_last) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("report byte mismatch at %0t: expected %02h last %b, %s",
                              $realtime, want.value, want.is_last,
                              $sformatf("got %02h last %b", rsp_report_byte,
                                        rsp_last_byte));
                  end
               end
            end
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == gre_pkg::CSR_NEUTRAL_HAT) begin
         cfg_hat = data[3:0];
      end else if (idx == gre_pkg::CSR_NEUTRAL_STICK) begin
         cfg_stick = data;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every event is taken and every byte has come, then let it settle
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_events.size() != 0 || req_valid || report_bytes_due.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   initial begin
      logic [7:0] hat_data;
      logic [7:0] stick_data;
      cfg_hat   = gre_pkg::NeutralHatReset;
      cfg_stick = gre_pkg::NeutralStickReset;
      load_neutral();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: button edges, unused indexes, every hat case, stick extremes
      queue_event(make_event(gre_pkg::OP_BUTTON, 4'd0, 4'h0, 1'b1, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_BUTTON, 4'd13, 4'hf, 1'b1, 1'b1, 8'hff, 8'hff));
      queue_event(make_event(gre_pkg::OP_BUTTON, 4'd14, 4'h0, 1'b1, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_BUTTON, 4'd15, 4'h0, 1'b0, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_BUTTON, 4'd0, 4'h0, 1'b0, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'h1, 1'b1, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'h8, 1'b1, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'h2, 1'b1, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'h1, 1'b0, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'h4, 1'b1, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'h8, 1'b0, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'h2, 1'b0, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'h1, 1'b1, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'hf, 1'b0, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'hf, 1'b1, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'h0, 1'b0, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_DIRECTION, 4'd0, 4'h3, 1'b0, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_STICK, 4'hf, 4'hf, 1'b1, 1'b0, 8'h00, 8'hff));
      queue_event(make_event(gre_pkg::OP_STICK, 4'h0, 4'h0, 1'b0, 1'b1, 8'hff, 8'h00));
      queue_event(make_event(gre_pkg::OP_STICK, 4'h0, 4'h0, 1'b0, 1'b0, 8'hff, 8'hff));
      queue_event(make_event(gre_pkg::OP_BUTTON, 4'd7, 4'h0, 1'b1, 1'b0, 8'h00, 8'h00));
      queue_event(make_event(gre_pkg::OP_NEUTRAL, 4'hf, 4'hf, 1'b1, 1'b1, 8'hff, 8'hff));
      wait_quiet();

      // random phases, each under a fresh pair of neutral values
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               hat_data   = 8'h00;
               stick_data = 8'h00;
            end
            1: begin
               hat_data   = 8'hff;
               stick_data = 8'hff;
            end
            default: begin
               hat_data   = 8'($urandom);
               stick_data = 8'($urandom);
            end
         endcase
         write_csr(gre_pkg::CSR_NEUTRAL_HAT, hat_data);
         write_csr((phase % 2 == 0) ? CsrSpareLo : CsrSpareHi, 8'($urandom));
         write_csr(gre_pkg::CSR_NEUTRAL_STICK, stick_data);
         queue_event(make_event(gre_pkg::OP_NEUTRAL, 4'($urandom), 4'($urandom),
                                1'($urandom), 1'($urandom), 8'($urandom),
                                8'($urandom)));
         for (int n = 0; n < 49; n++) begin
            queue_event(random_event());
         end
         wait_quiet();
      end

      if (report_bytes_due.size() != 0) begin
         error_count++;
      end
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // hard limit on the run
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/gre_pkg.sv
sv/gamepad_report_encoder_unit.sv
verif/gamepad_report_encoder_unit_test.sv
